[rtl/sov_pkg.sv]
package sov_pkg;

	localparam int MAX_VERTICES = 256;
	localparam int ADDR_W = $clog2(MAX_VERTICES);
	localparam int CNT_W = ADDR_W + 1;
	localparam int COORD_W = 16;
	localparam int DIFF_W = COORD_W + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [CROSS_W-1:0] cross_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} point_t;

	typedef struct packed {
		logic   closes;
		point_t pt;
	} vertex_t;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_ADD    = 2'd1,
		OP_QUERY  = 2'd2,
		OP_UNUSED = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_EVAL,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		ORI_ZERO,
		ORI_POS,
		ORI_NEG
	} ori_t;

	function automatic diff_t sub_c(input coord_t a, input coord_t b);
		return {a[COORD_W-1], a} - {b[COORD_W-1], b};
	endfunction

	function automatic cross_t sub_p(input prod_t a, input prod_t b);
		return {a[PROD_W-1], a} - {b[PROD_W-1], b};
	endfunction

	function automatic ori_t orient_code(input cross_t c);
		if (c == '0)
			return ORI_ZERO;
		else if (c[CROSS_W-1])
			return ORI_NEG;
		else
			return ORI_POS;
	endfunction

	// True when q lies within the bounding box of p and r.
	function automatic logic in_box(input point_t p, input point_t q, input point_t r);
		return ((q.x <= p.x) || (q.x <= r.x)) && ((q.x >= p.x) || (q.x >= r.x)) &&
			((q.y <= p.y) || (q.y <= r.y)) && ((q.y >= p.y) || (q.y >= r.y));
	endfunction

endpackage

[rtl/segment_obstacle_visibility.sv]
// Segment visibility against polygon obstacles held in an on-chip vertex memory.
//
// The input channel carries one command per beat: clear the store, add a vertex
// (closes_polygon marks the last vertex of a polygon), or query a segment given by
// its two endpoints. Every input beat yields exactly one output beat with visible
// and status. An add into a full store is dropped and answers status 1.
//
// Clear, add and the unused code are answered from the idle state. A query walks
// the stored vertices once through the single read port of the vertex memory:
// each vertex passes through the read, multiply and evaluate states, the closing
// edge of each polygon passes through multiply and evaluate once more, and the
// result is delivered from the done state. The walk stops at the first blocking
// polygon. One item is in work at a time; stall stays high during a query.
//
// Reset clears the vertex count and the control state; memory contents are
// not cleared, and entries at or above the count are never used. When the
// receiver stalls, the result beat holds in the output register, and a new
// command is taken only once that register can be freed in the same cycle.
module segment_obstacle_visibility (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               operation,
	input  logic signed [15:0]       first_x,
	input  logic signed [15:0]       first_y,
	input  logic signed [15:0]       second_x,
	input  logic signed [15:0]       second_y,
	input  logic                     closes_polygon,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     visible,
	output logic                     status
);
	import sov_pkg::*;

	state_t state_q, state_n;

	vertex_t mem [MAX_VERTICES];
	vertex_t rdata_q;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] idx_inc;

	point_t p1_q, p2_q, first_q, prev_q, ea_q, eb_q;
	logic newpoly_q, wrap_q, edge_en_q;
	logic isv1_q, isv2_q, in1_q, in2_q, hit_q;
	logic out_valid_q, visible_q, status_q;

	prod_t m1a_q, m1b_q, m2a_q, m2b_q, m3a_q, m3b_q, m4a_q, m4b_q;
	prod_t l1_q, r1_q, l2_q, r2_q;

	// Control strobes.
	logic accept, free, load_now, last_vertex, blocked;
	logic in1_n, in2_n, hit_n;

	point_t a_c, b_c;
	diff_t dpy, dpx, dby, dbx;
	ori_t o1, o2, o3, o4;
	logic meet, touch, cross1, cross2, d_pos;

	assign free = !out_valid_q || !out_stall;
	assign accept = in_valid && !in_stall;
	assign idx_inc = idx_q + 1'b1;
	assign last_vertex = (idx_inc == count_q);

	// Edge operands: a regular edge runs from the previous vertex to the one just
	// read; the closing edge runs from the last vertex back to the first.
	always_comb begin
		if (wrap_q) begin
			a_c = rdata_q.pt;
			b_c = first_q;
		end else begin
			a_c = prev_q;
			b_c = rdata_q.pt;
		end
		dpy = sub_c(p2_q.y, p1_q.y);
		dpx = sub_c(p2_q.x, p1_q.x);
		dby = sub_c(b_c.y, a_c.y);
		dbx = sub_c(b_c.x, a_c.x);
	end

	// Evaluation of the registered products for one edge.
	always_comb begin
		o1 = orient_code(sub_p(m1a_q, m1b_q));
		o2 = orient_code(sub_p(m2a_q, m2b_q));
		o3 = orient_code(sub_p(m3a_q, m3b_q));
		o4 = orient_code(sub_p(m4a_q, m4b_q));
		meet = ((o1 != o2) && (o3 != o4)) ||
			((o1 == ORI_ZERO) && in_box(p1_q, ea_q, p2_q)) ||
			((o2 == ORI_ZERO) && in_box(p1_q, eb_q, p2_q)) ||
			((o3 == ORI_ZERO) && in_box(ea_q, p1_q, eb_q)) ||
			((o4 == ORI_ZERO) && in_box(ea_q, p2_q, eb_q));
		touch = (p1_q == ea_q) || (p1_q == eb_q) || (p2_q == ea_q) || (p2_q == eb_q);
		d_pos = eb_q.y > ea_q.y;
		cross1 = (ea_q.y > p1_q.y) != (eb_q.y > p1_q.y);
		cross2 = (ea_q.y > p2_q.y) != (eb_q.y > p2_q.y);
		in1_n = in1_q;
		in2_n = in2_q;
		hit_n = hit_q;
		if (edge_en_q) begin
			if (cross1 && (d_pos ? (l1_q < r1_q) : (l1_q > r1_q)))
				in1_n = !in1_q;
			if (cross2 && (d_pos ? (l2_q < r2_q) : (l2_q > r2_q)))
				in2_n = !in2_q;
			if (meet && !touch)
				hit_n = 1'b1;
		end
		blocked = hit_n || (!isv1_q && in1_n) || (!isv2_q && in2_n);
	end

	// Next state.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (op_t'(operation) == OP_QUERY))
					state_n = (count_q == '0) ? ST_DONE : ST_READ;
			end
			ST_READ: state_n = ST_MUL;
			ST_MUL:  state_n = ST_EVAL;
			ST_EVAL: begin
				if (rdata_q.closes && !wrap_q)
					state_n = ST_MUL;
				else if (rdata_q.closes && blocked)
					state_n = ST_DONE;
				else if (last_vertex)
					state_n = ST_DONE;
				else
					state_n = ST_READ;
			end
			ST_DONE: begin
				if (free)
					state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// Outputs of the controller.
	always_comb begin
		in_stall = 1'b1;
		load_now = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = !free;
				load_now = accept && (op_t'(operation) != OP_QUERY);
			end
			ST_DONE: load_now = free;
			default: begin
				in_stall = 1'b1;
				load_now = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[idx_q[ADDR_W-1:0]];
		if (accept && (op_t'(operation) == OP_ADD) && (count_q != CNT_W'(MAX_VERTICES)))
			mem[count_q[ADDR_W-1:0]] <= '{closes: closes_polygon, pt: '{x: first_x, y: first_y}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q <= '0;
			newpoly_q <= 1'b1;
			wrap_q <= 1'b0;
			edge_en_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (load_now)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (accept) begin
				case (op_t'(operation))
					OP_CLEAR: count_q <= '0;
					OP_ADD: begin
						if (count_q != CNT_W'(MAX_VERTICES))
							count_q <= count_q + 1'b1;
					end
					OP_QUERY: begin
						idx_q <= '0;
						newpoly_q <= 1'b1;
						wrap_q <= 1'b0;
					end
					default: ;
				endcase
			end
			if (state_q == ST_MUL)
				edge_en_q <= wrap_q || !newpoly_q;
			if (state_q == ST_EVAL) begin
				if (rdata_q.closes && !wrap_q) begin
					wrap_q <= 1'b1;
				end else begin
					wrap_q <= 1'b0;
					newpoly_q <= rdata_q.closes;
					idx_q <= idx_inc;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			p1_q <= '{x: first_x, y: first_y};
			p2_q <= '{x: second_x, y: second_y};
			if (load_now) begin
				visible_q <= 1'b0;
				status_q <= (op_t'(operation) == OP_ADD) &&
					(count_q == CNT_W'(MAX_VERTICES));
			end else begin
				// A query starts out visible until a closed polygon blocks it.
				visible_q <= 1'b1;
			end
		end else if (load_now) begin
			// Query result: visible_q already holds the outcome of the walk.
			status_q <= 1'b0;
		end
		if (state_q == ST_MUL) begin
			ea_q <= a_c;
			eb_q <= b_c;
			m1a_q <= dpy * sub_c(a_c.x, p2_q.x);
			m1b_q <= dpx * sub_c(a_c.y, p2_q.y);
			m2a_q <= dpy * sub_c(b_c.x, p2_q.x);
			m2b_q <= dpx * sub_c(b_c.y, p2_q.y);
			m3a_q <= dby * sub_c(p1_q.x, b_c.x);
			m3b_q <= dbx * sub_c(p1_q.y, b_c.y);
			m4a_q <= dby * sub_c(p2_q.x, b_c.x);
			m4b_q <= dbx * sub_c(p2_q.y, b_c.y);
			l1_q <= sub_c(p1_q.x, a_c.x) * dby;
			r1_q <= dbx * sub_c(p1_q.y, a_c.y);
			l2_q <= sub_c(p2_q.x, a_c.x) * dby;
			r2_q <= dbx * sub_c(p2_q.y, a_c.y);
			if (!wrap_q) begin
				if (newpoly_q) begin
					first_q <= rdata_q.pt;
					isv1_q <= (rdata_q.pt == p1_q);
					isv2_q <= (rdata_q.pt == p2_q);
					in1_q <= 1'b0;
					in2_q <= 1'b0;
					hit_q <= 1'b0;
				end else begin
					isv1_q <= isv1_q || (rdata_q.pt == p1_q);
					isv2_q <= isv2_q || (rdata_q.pt == p2_q);
				end
			end
		end
		if (state_q == ST_EVAL) begin
			in1_q <= in1_n;
			in2_q <= in2_n;
			hit_q <= hit_n;
			if (!rdata_q.closes)
				prev_q <= rdata_q.pt;
			else if (wrap_q) begin
				// A polygon is finished: a blocking one makes the segment not visible.
				if (blocked)
					visible_q <= 1'b0;
				prev_q <= rdata_q.pt;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign visible = visible_q;
	assign status = status_q;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

// Testbench for segment_obstacle_visibility.
// An initial block builds a list of command beats: a short directed part that
// covers each command, coordinate extremes and the polygon corner cases, then a
// full-store fill, then random polygons, queries and clears. A clocked driver presents
// the beats, and every accepted beat is run through a local model of the
// vertex store to predict its result. A clocked monitor compares each
// accepted result beat with the oldest prediction.
module tb_top;
	import sov_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int STORE_DEPTH = MAX_VERTICES;

	typedef struct {
		op_t              op;
		logic signed [15:0] fx;
		logic signed [15:0] fy;
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic             closes;
		bit               drain_first;
	} command_t;

	typedef struct {
		logic visible;
		logic status;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] operation = '0;
	logic signed [15:0] first_x = '0;
	logic signed [15:0] first_y = '0;
	logic signed [15:0] second_x = '0;
	logic signed [15:0] second_y = '0;
	logic closes_polygon = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic visible;
	logic status;

	command_t pending_cmds[$];
	answer_t expected_answers[$];
	int mismatches = 0;
	int beats_sent = 0;
	int quiet_cycles = 0;

	// Local copy of the obstacle store used for prediction.
	longint model_x[STORE_DEPTH];
	longint model_y[STORE_DEPTH];
	bit model_closes[STORE_DEPTH];
	int model_count = 0;

	// Vertices of the polygon most recently queued, so that some queries can
	// reuse them as endpoints.
	longint recent_x[$];
	longint recent_y[$];

	segment_obstacle_visibility dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.first_x(first_x),
		.first_y(first_y),
		.second_x(second_x),
		.second_y(second_y),
		.closes_polygon(closes_polygon),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.visible(visible),
		.status(status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Orientation of the turn p -> q -> r, exact.
	function automatic ori_t turn_of(longint px, longint py, longint qx, longint qy,
		longint rx, longint ry);
		longint v;
		v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
		if (v == 0) begin
			return ORI_ZERO;
		end
		return (v > 0) ? ORI_POS : ORI_NEG;
	endfunction

	function automatic bit within_box(longint px, longint py, longint qx, longint qy,
		longint rx, longint ry);
		return qx <= ((px > rx) ? px : rx) && qx >= ((px < rx) ? px : rx) &&
			qy <= ((py > ry) ? py : ry) && qy >= ((py < ry) ? py : ry);
	endfunction

	function automatic bit segments_touch(longint ax, longint ay, longint bx, longint by,
		longint cx, longint cy, longint dx, longint dy);
		ori_t o1, o2, o3, o4;
		o1 = turn_of(ax, ay, bx, by, cx, cy);
		o2 = turn_of(ax, ay, bx, by, dx, dy);
		o3 = turn_of(cx, cy, dx, dy, ax, ay);
		o4 = turn_of(cx, cy, dx, dy, bx, by);
		if (o1 != o2 && o3 != o4) begin
			return 1'b1;
		end
		return (o1 == ORI_ZERO && within_box(ax, ay, cx, cy, bx, by)) ||
			(o2 == ORI_ZERO && within_box(ax, ay, dx, dy, bx, by)) ||
			(o3 == ORI_ZERO && within_box(cx, cy, ax, ay, dx, dy)) ||
			(o4 == ORI_ZERO && within_box(cx, cy, bx, by, dx, dy));
	endfunction

	function automatic bit is_corner(longint px, longint py, int s, int e);
		for (int i = s; i <= e; i++) begin
			if (model_x[i] == px && model_y[i] == py) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Crossing parity test without division.
	function automatic bit point_enclosed(longint px, longint py, int s, int e);
		bit odd;
		int j;
		longint d, lhs, rhs;
		odd = 1'b0;
		j = e;
		for (int i = s; i <= e; i++) begin
			if ((model_y[i] > py) != (model_y[j] > py)) begin
				d = model_y[j] - model_y[i];
				lhs = (px - model_x[i]) * d;
				rhs = (model_x[j] - model_x[i]) * (py - model_y[i]);
				if ((d > 0) ? (lhs < rhs) : (lhs > rhs)) begin
					odd = !odd;
				end
			end
			j = i;
		end
		return odd;
	endfunction

	function automatic bit polygon_blocks(longint ax, longint ay, longint bx, longint by,
		int s, int e);
		int n;
		if (!is_corner(ax, ay, s, e) && point_enclosed(ax, ay, s, e)) begin
			return 1'b1;
		end
		if (!is_corner(bx, by, s, e) && point_enclosed(bx, by, s, e)) begin
			return 1'b1;
		end
		for (int i = s; i <= e; i++) begin
			n = (i == e) ? s : i + 1;
			if (segments_touch(ax, ay, bx, by, model_x[i], model_y[i], model_x[n], model_y[n])
				&& !((ax == model_x[i] && ay == model_y[i]) ||
				(ax == model_x[n] && ay == model_y[n]) ||
				(bx == model_x[i] && by == model_y[i]) ||
				(bx == model_x[n] && by == model_y[n]))) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Applies one accepted command to the local store and returns its answer.
	function automatic answer_t apply_command(logic [1:0] op, longint fx, longint fy,
		longint sx, longint sy, logic closes);
		answer_t a;
		int start;
		a.visible = 1'b0;
		a.status = 1'b0;
		case (op_t'(op))
			OP_CLEAR: begin
				model_count = 0;
			end
			OP_ADD: begin
				if (model_count >= STORE_DEPTH) begin
					a.status = 1'b1;
				end else begin
					model_x[model_count] = fx;
					model_y[model_count] = fy;
					model_closes[model_count] = closes;
					model_count++;
				end
			end
			OP_QUERY: begin
				a.visible = 1'b1;
				start = 0;
				for (int i = 0; i < model_count && a.visible; i++) begin
					if (model_closes[i]) begin
						if (polygon_blocks(fx, fy, sx, sy, start, i)) begin
							a.visible = 1'b0;
						end
						start = i + 1;
					end
				end
			end
			default: begin
			end
		endcase
		return a;
	endfunction

	task automatic queue_command(op_t op, int fx, int fy, int sx, int sy, bit closes,
		bit drain_first = 1'b0);
		command_t c;
		c.op = op;
		c.fx = fx[15:0];
		c.fy = fy[15:0];
		c.sx = sx[15:0];
		c.sy = sy[15:0];
		c.closes = closes;
		c.drain_first = drain_first;
		pending_cmds = {pending_cmds, c};
	endtask

	// Mostly small coordinates so that segments and polygons interact,
	// sometimes the full signed range.
	function automatic int pick_coord();
		if ($urandom_range(99) < 15) begin
			return int'($signed(16'($urandom)));
		end
		return int'($urandom_range(80)) - 40;
	endfunction

	task automatic queue_query();
		int p[4];
		int k;
		for (int i = 0; i < 4; i++) begin
			p[i] = pick_coord();
		end
		// Reuse polygon corners as endpoints now and then.
		for (int i = 0; i < 2; i++) begin
			if (recent_x.size() > 0 && $urandom_range(99) < 30) begin
				k = $urandom_range(recent_x.size() - 1);
				p[2 * i] = int'(recent_x[k]);
				p[2 * i + 1] = int'(recent_y[k]);
			end
		end
		queue_command(OP_QUERY, p[0], p[1], p[2], p[3], 1'($urandom_range(1)));
	endtask

	task automatic report_mismatch(string field, logic got, logic want);
		$display("mismatch on %s: got %0b, expected %0b at %0t", field, got, want, $realtime);
		mismatches++;
	endtask

	// Idle and stall rates change every hundred beats: none, sender idle,
	// receiver stalling, then both.
	function automatic int sender_idle_pct();
		case ((beats_sent / 100) % 4)
			1: return 76;
			3: return 36;
			default: return 0;
		endcase
	endfunction

	function automatic int receiver_stall_pct();
		case ((beats_sent / 100) % 4)
			2: return 76;
			3: return 36;
			default: return 0;
		endcase
	endfunction

	// Driver. A beat is predicted at the edge where it is accepted; the next one
	// is then presented or valid drops, with a single assignment per edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_answers = {expected_answers, apply_command(operation, first_x,
					first_y, second_x, second_y, closes_polygon)};
				beats_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_cmds.size() > 0 &&
					!(pending_cmds[0].drain_first && (expected_answers.size() > 0 ||
					(in_valid && !in_stall))) &&
					$urandom_range(99) >= sender_idle_pct()) begin
					operation <= pending_cmds[0].op;
					first_x <= pending_cmds[0].fx;
					first_y <= pending_cmds[0].fy;
					second_x <= pending_cmds[0].sx;
					second_y <= pending_cmds[0].sy;
					closes_polygon <= pending_cmds[0].closes;
					in_valid <= 1'b1;
					void'(pending_cmds.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor, receiver stall and watchdog.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			out_stall <= ($urandom_range(99) < receiver_stall_pct());
			if (out_valid && !out_stall) begin
				if (expected_answers.size() == 0) begin
					// A result beat arrived with nothing expected.
					report_mismatch("out_valid", 1'b1, 1'b0);
				end else begin
					if (visible !== expected_answers[0].visible) begin
						report_mismatch("visible", visible, expected_answers[0].visible);
					end
					if (status !== expected_answers[0].status) begin
						report_mismatch("status", status, expected_answers[0].status);
					end
					void'(expected_answers.pop_front());
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int n;
		bit drain_queued;
		drain_queued = 1'b0;
		// Directed part: triangle with corners (0,0), (100,0), (0,100).
		queue_command(OP_QUERY, 1, 1, 5, 5, 1'b0);             // empty store
		queue_command(OP_ADD, 0, 0, 0, 0, 1'b0);
		queue_command(OP_ADD, 100, 0, 0, 0, 1'b0);
		queue_command(OP_QUERY, 10, 10, 20, 20, 1'b0);         // open tail only
		queue_command(OP_ADD, 0, 100, 0, 0, 1'b1);
		queue_command(OP_QUERY, 10, 10, 200, 200, 1'b0);       // endpoint inside
		queue_command(OP_QUERY, -50, 50, 150, 50, 1'b0);       // crosses edges
		queue_command(OP_QUERY, 0, 0, 100, 0, 1'b0);           // along an edge, corners
		queue_command(OP_QUERY, 0, 0, -20, -30, 1'b0);         // from a corner outward
		queue_command(OP_QUERY, 200, 200, 300, 100, 1'b0);     // far outside
		queue_command(OP_UNUSED, 5, 5, 5, 5, 1'b1);
		// Single point obstacle and a two-vertex one.
		queue_command(OP_ADD, 500, 500, 0, 0, 1'b1);
		queue_command(OP_QUERY, 400, 400, 600, 600, 1'b0);     // passes through the point
		queue_command(OP_QUERY, 500, 500, 600, 600, 1'b0);     // ends on the point
		queue_command(OP_ADD, -300, -300, 0, 0, 1'b0);
		queue_command(OP_ADD, -200, -300, 0, 0, 1'b1);
		queue_command(OP_QUERY, -250, -400, -250, -200, 1'b0);
		// Coordinate extremes.
		queue_command(OP_ADD, -32768, -32768, 0, 0, 1'b0);
		queue_command(OP_ADD, 32767, -32768, 0, 0, 1'b0);
		queue_command(OP_ADD, 32767, 32767, 0, 0, 1'b1);
		queue_command(OP_QUERY, 32767, -32768, -32768, 32767, 1'b1);
		queue_command(OP_QUERY, -32768, 32767, 32767, -32768, 1'b0);
		queue_command(OP_CLEAR, -1, -1, -1, -1, 1'b1);
		queue_command(OP_QUERY, 10, 10, 200, 200, 1'b0);

		// Fill the store, overflow it, then query it twice while full.
		for (int i = 0; i < STORE_DEPTH + 2; i++) begin
			queue_command(OP_ADD, pick_coord(), pick_coord(), 0, 0, (i % 4) == 3);
		end
		queue_query();
		queue_query();
		queue_command(OP_CLEAR, 0, 0, 0, 0, 1'b0);

		// Random part: polygons with random content, queries, clears and noise.
		while (pending_cmds.size() < 1100) begin
			n = $urandom_range(99);
			if (n < 8) begin
				queue_command(OP_CLEAR, pick_coord(), pick_coord(), pick_coord(),
					pick_coord(), 1'($urandom_range(1)));
			end else if (n < 13) begin
				queue_command(op_t'($urandom_range(3)), pick_coord(), pick_coord(),
					pick_coord(), pick_coord(), 1'($urandom_range(1)));
			end else if (n < 55) begin
				recent_x.delete();
				recent_y.delete();
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++) begin
					recent_x = {recent_x, longint'(pick_coord())};
					recent_y = {recent_y, longint'(pick_coord())};
					// Occasionally the polygon is left open.
					queue_command(OP_ADD, int'(recent_x[i]), int'(recent_y[i]), pick_coord(),
						pick_coord(), (i == n - 1) && ($urandom_range(9) != 0));
				end
			end else begin
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++) begin
					queue_query();
				end
			end
			// Once, hold the sender back until every result has come.
			if (!drain_queued && pending_cmds.size() >= 700) begin
				queue_command(OP_QUERY, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
					1'b0, 1'b1);
				drain_queued = 1'b1;
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() > 0 || in_valid || expected_answers.size() > 0) begin
			@(posedge clk);
		end
		repeat (50) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/sov_pkg.sv
rtl/segment_obstacle_visibility.sv
tb/tb_top.sv
